// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: hdl/wrs_pkg.sv
// Types and constants shared by the water ripple stencil modules.
`default_nettype none

package wrs_pkg;

  localparam int unsigned FrameWidth  = 288;
  localparam int unsigned FrameHeight = 224;

  localparam int unsigned ColW     = $clog2(FrameWidth);
  localparam int unsigned RowW     = $clog2(FrameHeight);
  localparam int unsigned PosW     = $clog2(FrameWidth * FrameHeight);
  localparam int unsigned DlyDepth = FrameWidth + 1;
  localparam int unsigned DlyW     = $clog2(DlyDepth);

  // The queue depth must be a power of two so that the pointers wrap by themselves.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QLvlW  = $clog2(QDepth + 1);

  localparam int unsigned HeightW = 16;
  localparam int unsigned IndexW  = 16;
  localparam int unsigned DampW   = 4;
  localparam int unsigned SumW    = HeightW + 3;

  // Rows and columns before the first interior window is complete.
  localparam int unsigned Margin = 2;

  localparam logic [ColW-1:0]  ColLast    = ColW'(FrameWidth - 1);
  localparam logic [RowW-1:0]  RowLast    = RowW'(FrameHeight - 1);
  localparam logic [DlyW-1:0]  DlyLast    = DlyW'(DlyDepth - 1);
  localparam logic [ColW-1:0]  ColMargin  = ColW'(Margin);
  localparam logic [RowW-1:0]  RowMargin  = RowW'(Margin);
  localparam logic [PosW-1:0]  CenterOfs  = PosW'(FrameWidth + 1);
  localparam logic [DampW-1:0] DampReset  = DampW'(5);

  localparam logic signed [HeightW-1:0] SatMax = 16'sh7FFF;
  localparam logic signed [HeightW-1:0] SatMin = 16'sh8000;

  typedef struct packed {
    logic signed [HeightW-1:0] height_now;
    logic signed [HeightW-1:0] height_older;
    logic                      frame_start;
  } in_item_t;

  typedef struct packed {
    logic        [IndexW-1:0]  pixel_index;
    logic signed [HeightW-1:0] new_height;
  } out_item_t;

  // One interior pixel waiting for the damping arithmetic.
  typedef struct packed {
    logic        [IndexW-1:0]  pixel_index;
    logic signed [SumW-1:0]    sum;
    logic signed [HeightW-1:0] center_older;
  } job_t;

  typedef struct packed {
    logic [QLvlW-1:0] level;
    logic             not_empty;
  } q_stat_t;

endpackage

`default_nettype wire

// File: hdl/wrs_front.sv
// Front end: raster counters, line store, older-height delay, 3x3 window and neighbor sum.
`default_nettype none

module wrs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wrs_pkg::in_item_t in_data_i,
  input  wrs_pkg::q_stat_t  q_stat_i,
  output logic              push_o,
  output wrs_pkg::job_t     job_o
);
  import wrs_pkg::*;

  typedef struct packed {
    logic signed [HeightW-1:0] top;
    logic signed [HeightW-1:0] mid;
  } line_t;

  line_t                     line_mem [FrameWidth];
  logic signed [HeightW-1:0] dly_mem  [DlyDepth];

  logic [ColW-1:0] col_q, col_d, col_eff;
  logic [RowW-1:0] row_q, row_d, row_eff;
  logic [PosW-1:0] pos_q, pos_d, pos_eff;
  logic [DlyW-1:0] dly_ptr_q, dly_ptr_d;

  logic                      in_accept;
  logic [QLvlW:0]            occ;
  logic                      s1_valid_q;
  logic                      s1_fwd_q;
  logic                      s1_emit_q;
  logic [ColW-1:0]           s1_col_q;
  logic [IndexW-1:0]         s1_idx_q;
  logic signed [HeightW-1:0] s1_now_q;
  line_t                     line_rd_q, last_wr_q, line_rd, line_wr;
  logic signed [HeightW-1:0] dly_rd_q;
  logic signed [HeightW-1:0] tap_q [6];
  logic signed [SumW-1:0]    sum;

  // Room is counted for the item already in the read stage.
  assign occ        = {1'b0, q_stat_i.level} + {{QLvlW{1'b0}}, s1_valid_q};
  assign in_ready_o = (occ < (QLvlW + 1)'(QDepth));
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    col_eff = in_data_i.frame_start ? '0 : col_q;
    row_eff = in_data_i.frame_start ? '0 : row_q;
    pos_eff = in_data_i.frame_start ? '0 : pos_q;
    col_d   = col_eff + ColW'(1);
    row_d   = row_eff;
    pos_d   = pos_eff + PosW'(1);
    if (col_eff == ColLast) begin
      col_d = '0;
      if (row_eff == RowLast) begin
        row_d = '0;
        pos_d = '0;
      end else begin
        row_d = row_eff + RowW'(1);
      end
    end
    dly_ptr_d = (dly_ptr_q == DlyLast) ? '0 : dly_ptr_q + DlyW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      pos_q      <= '0;
      dly_ptr_q  <= '0;
      s1_valid_q <= 1'b0;
      s1_fwd_q   <= 1'b0;
      tap_q      <= '{default: '0};
    end else begin
      s1_valid_q <= in_accept;
      if (in_accept) begin
        col_q     <= col_d;
        row_q     <= row_d;
        pos_q     <= pos_d;
        dly_ptr_q <= dly_ptr_d;
        // The previous item writes this same column at this edge, so its data is forwarded.
        s1_fwd_q  <= s1_valid_q && (s1_col_q == col_eff);
      end
      if (s1_valid_q) begin
        tap_q[0] <= tap_q[3];
        tap_q[1] <= tap_q[4];
        tap_q[2] <= tap_q[5];
        tap_q[3] <= line_rd.top;
        tap_q[4] <= line_rd.mid;
        tap_q[5] <= s1_now_q;
      end
    end
  end

  // Both stores are read before they are written at the same address.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      line_rd_q          <= line_mem[col_eff];
      dly_rd_q           <= dly_mem[dly_ptr_q];
      dly_mem[dly_ptr_q] <= in_data_i.height_older;
      s1_col_q           <= col_eff;
      s1_now_q           <= in_data_i.height_now;
      s1_emit_q          <= (row_eff >= RowMargin) && (col_eff >= ColMargin);
      s1_idx_q           <= IndexW'(pos_eff - CenterOfs);
    end
    if (s1_valid_q) begin
      line_mem[s1_col_q] <= line_wr;
      last_wr_q          <= line_wr;
    end
  end

  always_comb begin
    line_rd     = s1_fwd_q ? last_wr_q : line_rd_q;
    line_wr.top = line_rd.mid;
    line_wr.mid = s1_now_q;
    sum = SumW'(tap_q[0]) + SumW'(tap_q[1]) + SumW'(tap_q[2]) + SumW'(tap_q[3])
        + SumW'(tap_q[5]) + SumW'(line_rd.top) + SumW'(line_rd.mid) + SumW'(s1_now_q);
  end

  assign push_o             = s1_valid_q && s1_emit_q;
  assign job_o.pixel_index  = s1_idx_q;
  assign job_o.sum          = sum;
  assign job_o.center_older = dly_rd_q;

endmodule

`default_nettype wire

// File: hdl/wrs_queue.sv
// Short queue of pending interior pixels between the front and back ends.
`default_nettype none

module wrs_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wrs_pkg::job_t    push_data_i,
  input  logic             pop_i,
  output wrs_pkg::job_t    pop_data_o,
  output wrs_pkg::q_stat_t stat_o
);
  import wrs_pkg::*;

  job_t             slot_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QLvlW-1:0] level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   level_q <= level_q + QLvlW'(1);
        2'b01:   level_q <= level_q - QLvlW'(1);
        default: level_q <= level_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o       = slot_q[rd_ptr_q];
  assign stat_o.level     = level_q;
  assign stat_o.not_empty = (level_q != '0);

endmodule

`default_nettype wire

// File: hdl/wrs_back.sv
// Back end: damping register, damping arithmetic, saturation and output register.
`default_nettype none

module wrs_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [wrs_pkg::DampW-1:0]   cfg_data_i,
  input  wrs_pkg::q_stat_t            stat_i,
  input  wrs_pkg::job_t               job_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output wrs_pkg::out_item_t          out_data_o
);
  import wrs_pkg::*;

  logic [DampW-1:0]          damp_q;
  logic                      out_valid_q;
  out_item_t                 out_q, out_d;
  logic signed [SumW-2:0]    v;
  logic signed [SumW-1:0]    r;

  assign cfg_ready_o = 1'b1;
  assign pop_o       = stat_i.not_empty && (!out_valid_q || out_ready_i);

  always_comb begin
    v = (SumW - 1)'(job_i.sum >>> 2) - (SumW - 1)'(job_i.center_older);
    r = SumW'(v) - SumW'(v >>> damp_q);
    out_d.pixel_index = job_i.pixel_index;
    priority if (r > SumW'(SatMax)) begin
      out_d.new_height = SatMax;
    end else if (r < SumW'(SatMin)) begin
      out_d.new_height = SatMin;
    end else begin
      out_d.new_height = HeightW'(r);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damp_q      <= DampReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        damp_q <= cfg_data_i;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: hdl/water_ripple_stencil.sv
// Top level of the water ripple stencil: front end, queue and back end.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o   | in_data_i  (in_item_t)
//   out     | output    | out_valid_o / out_ready_i | out_data_o (out_item_t)
//   cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_data_i (damping shift)
//
// One pixel is taken per clock while input ready is high. The line store is read into
// the read stage, an interior pixel's neighbor sum goes into the queue, and the
// damping result of the queue head goes to the output register. The four-entry queue
// absorbs output stalls; input ready drops when queue plus read stage hold four.
// Reset clears counters, window taps and the queue; the line stores need no clearing.
// The configuration port is always ready.
`default_nettype none

module water_ripple_stencil (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  wrs_pkg::in_item_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output wrs_pkg::out_item_t        out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [wrs_pkg::DampW-1:0] cfg_data_i
);
  import wrs_pkg::*;

  logic    push, pop;
  job_t    push_job, pop_job;
  q_stat_t q_stat;

  wrs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .job_o      (push_job)
  );

  wrs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .stat_o      (q_stat)
  );

  wrs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .stat_i      (q_stat),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// File: hdl/wrs_checker.sv
// Port-level checker for the water ripple stencil, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module wrs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input wrs_pkg::in_item_t         in_data_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input wrs_pkg::out_item_t        out_data_o,
  input logic                      cfg_valid_i,
  input logic                      cfg_ready_o,
  input logic [wrs_pkg::DampW-1:0] cfg_data_i
);
  import wrs_pkg::*;

  logic [DampW-1:0] damp_q;
  logic             in_seen;

  // Shadow copy of the damping register as written through the port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damp_q <= DampReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      damp_q <= cfg_data_i;
    end
  end

  assign in_seen = in_valid_i && in_data_i.frame_start;

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `ASSERT_IMPL(a_cfg_ready, clk_i, rst_ni, 1'b1, cfg_ready_o)
  `ASSERT_IMPL(a_zero_damp, clk_i, rst_ni, out_valid_o && (damp_q == '0), out_data_o.new_height == '0)
  `ASSERT_IMPL(a_idle_ready, clk_i, rst_ni, !out_valid_o || in_seen, in_ready_o || out_valid_o)

endmodule

bind water_ripple_stencil wrs_checker u_wrs_checker (.*);

`default_nettype wire

// File: tb/sv/water_ripple_stencil_tb.sv
// Self-checking testbench for the water ripple stencil with a per-pixel height predictor.
module water_ripple_stencil_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wrs_pkg::*;

  localparam int unsigned WindowFill   = 2 * FrameWidth + 6;
  localparam int unsigned SpotItems    = 40;
  localparam int unsigned RandomItems  = 440;
  localparam int unsigned PhaseItems   = 110;
  localparam int unsigned SettleCycles = 8;
  localparam longint unsigned CycleLimit = 600_000;

  typedef enum int {PressNone, PressSender, PressReceiver, PressBoth} pressure_e;

  // One directed segment: count pixels of uniform or random heights, optionally opening a frame.
  typedef struct packed {
    int unsigned               count;
    bit                        restart;
    logic signed [HeightW-1:0] now;
    logic signed [HeightW-1:0] older;
    bit                        fill_random;
    logic [DampW-1:0]          shift;
    bit                        pinned;
    logic signed [HeightW-1:0] pin;
  } surface_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  in_item_t         in_data_i;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_item_t        out_data_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [DampW-1:0] cfg_data_i;

  // Predictor state.
  int               prev_rows [2*FrameWidth];
  int               older_line [DlyDepth];
  int unsigned      older_ptr;
  int unsigned      col_pos;
  int unsigned      row_pos;
  int               taps [6];
  logic [DampW-1:0] damp_shift = DampReset;
  out_item_t        pending_heights [$];

  int unsigned      errors;
  int unsigned      send_idle_pct;
  int unsigned      stall_pct;
  longint unsigned  cycles;

  // The first segment fills two rows and six pixels of a third with the largest heights
  // under the reset damping; the others run on in the same row.
  surface_row_t fill_plan [3] = '{
    '{WindowFill, 1'b1, SatMax, SatMax, 1'b0, 4'd5, 1'b1, 16'sd31744},
    '{SpotItems, 1'b0, 16'sd0, 16'sd0, 1'b1, 4'd0, 1'b1, 16'sd0},
    '{SpotItems, 1'b0, 16'sd0, 16'sd0, 1'b1, 4'd15, 1'b0, 16'sd0}
  };

  water_ripple_stencil u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4ns clk_i = 1'b1;
    #4ns clk_i = 1'b0;
  end

  // Advances the window by one pixel and queues the new height it completes, if any.
  function automatic bit ripple_predict(input in_item_t px);
    int        c;
    int        top;
    int        mid;
    int        now;
    int        center;
    int        sum;
    int        v;
    int        r;
    bit        made;
    out_item_t res;
    made = 1'b0;
    if (px.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    c   = col_pos;
    now = int'($signed(px.height_now));
    top = prev_rows[FrameWidth + c];
    mid = prev_rows[c];
    prev_rows[FrameWidth + c] = mid;
    prev_rows[c] = now;

    center = older_line[older_ptr];
    older_line[older_ptr] = int'($signed(px.height_older));
    older_ptr = (older_ptr + 1 >= DlyDepth) ? 0 : older_ptr + 1;

    if (row_pos >= Margin && c >= Margin) begin
      sum = taps[0] + taps[1] + taps[2] + taps[3] + taps[5] + top + mid + now;
      v = (sum >>> 2) - center;
      r = v - (v >>> damp_shift);
      if (r > int'(SatMax)) begin
        r = int'(SatMax);
      end else if (r < int'(SatMin)) begin
        r = int'(SatMin);
      end
      res.pixel_index = IndexW'((row_pos - 1) * FrameWidth + (c - 1));
      res.new_height  = HeightW'(r);
      pending_heights.push_back(res);
      made = 1'b1;
    end

    taps[0] = taps[3];
    taps[1] = taps[4];
    taps[2] = taps[5];
    taps[3] = top;
    taps[4] = mid;
    taps[5] = now;

    col_pos++;
    if (col_pos >= FrameWidth) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= FrameHeight) begin
        row_pos = 0;
      end
    end
    return made;
  endfunction

  function automatic logic signed [HeightW-1:0] rand_height();
    case ($urandom_range(0, 15))
      0: return SatMax;
      1: return SatMin;
      2: return '0;
      3: return '1;
      default: return HeightW'($urandom);
    endcase
  endfunction

  task automatic set_pressure(input pressure_e mode);
    case (mode)
      PressNone: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      PressSender: begin
        send_idle_pct = 60;
        stall_pct     = 0;
      end
      PressReceiver: begin
        send_idle_pct = 0;
        stall_pct     = 60;
      end
      default: begin
        send_idle_pct = 9;
        stall_pct     = 9;
      end
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_pixel(input in_item_t px, input bit pinned,
                            input logic signed [HeightW-1:0] pin);
    out_item_t last;
    bit        made;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (!in_ready_o);
    made = ripple_predict(px);
    // Rows with a hand-computed height check the block against that value.
    if (made && pinned) begin
      last = pending_heights.pop_back();
      last.new_height = pin;
      pending_heights.push_back(last);
    end
    @(negedge clk_i);
  endtask

  // The block must be idle: wait for every result, then let the pipeline settle.
  task automatic write_damping(input logic [DampW-1:0] shift);
    in_valid_i <= 1'b0;
    while (pending_heights.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= shift;
    do @(posedge clk_i); while (!cfg_ready_o);
    damp_shift = shift;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_heights.size() == 0) begin
        $error("unexpected result: pixel_index %0d new_height %0d",
               out_data_o.pixel_index, $signed(out_data_o.new_height));
        errors++;
      end else begin
        want = pending_heights.pop_front();
        if (out_data_o.pixel_index !== want.pixel_index) begin
          $error("pixel_index: expected %0d, got %0d", want.pixel_index,
                 out_data_o.pixel_index);
          errors++;
        end
        if (out_data_o.new_height !== want.new_height) begin
          $error("new_height: expected %0d, got %0d", $signed(want.new_height),
                 $signed(out_data_o.new_height));
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    in_item_t    px;
    int unsigned sent;
    int unsigned phase;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    set_pressure(PressNone);
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed segments; only the first one opens a frame.
    foreach (fill_plan[i]) begin
      if (fill_plan[i].shift != damp_shift) begin
        write_damping(fill_plan[i].shift);
      end
      for (int unsigned k = 0; k < fill_plan[i].count; k++) begin
        px.frame_start  = fill_plan[i].restart && (k == 0);
        px.height_now   = fill_plan[i].fill_random ? rand_height() : fill_plan[i].now;
        px.height_older = fill_plan[i].fill_random ? rand_height() : fill_plan[i].older;
        send_pixel(px, fill_plan[i].pinned, fill_plan[i].pin);
      end
    end

    // Random pixels running on in the same frame with rare restarts, cycling idle patterns.
    sent  = 0;
    phase = 0;
    while (sent < RandomItems) begin
      if (sent % PhaseItems == 0) begin
        write_damping(DampW'($urandom_range(0, 15)));
        set_pressure(pressure_e'(phase % 4));
        phase++;
      end
      px.frame_start  = ($urandom_range(0, 699) == 0);
      px.height_now   = rand_height();
      px.height_older = rand_height();
      send_pixel(px, 1'b0, '0);
      sent++;
    end

    in_valid_i <= 1'b0;
    while (pending_heights.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
